/* design/second_chance_page_replacement_assert.svh */
// ----------------------------------------------------------------------------
// Second chance page replacement: assertion macros
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SECOND_CHANCE_PAGE_REPLACEMENT_ASSERT_SVH
`define SECOND_CHANCE_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define SCPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset
`define SCPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define SCPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* design/scpr_pkg.sv */
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared types and fixed widths of the second chance page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package scpr_pkg;

  // Fixed field widths
  localparam int CFG_W   = 5;
  localparam int FAULT_W = 16;

  // Frame count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } scpr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } scpr_cmd_t;

endpackage

`default_nettype wire

/* design/scpr_ctrl.sv */
// ----------------------------------------------------------------------------
// scpr_ctrl
// Request sequencer: load, search, commit. A new request is taken while the
// previous one commits.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_ctrl
  import scpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output scpr_cmd_t      cmd
);

  scpr_state_t state_r;
  scpr_state_t state_nxt;
  logic        take;

  assign take = start && !busy;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = take ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    busy       = 1'b0;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SEARCH: begin
        busy       = 1'b1;
        cmd.search = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.load   = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/scpr_datapath.sv */
// ----------------------------------------------------------------------------
// scpr_datapath
// Frame tags, valid and use bits, clock hand, fault counter, parallel tag
// compare, find-first-clear search from the hand, and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "second_chance_page_replacement_assert.svh"

module scpr_datapath
  import scpr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scpr_cmd_t            cmd,
  input  wire logic [PAGE_BITS-1:0] in_page_number,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output logic                      out_valid,
  output logic                      out_was_hit,
  output logic [FIDX_W-1:0]         out_frame_index,
  output logic                      out_evicted_valid,
  output logic [PAGE_BITS-1:0]      out_evicted_page,
  output logic [FAULT_W-1:0]        out_faults_so_far
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // State
  logic [CFG_W-1:0]     cfg_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] frame_page_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r;
  logic [MAX_FRAMES-1:0] use_r;
  logic [MAX_FRAMES-1:0] use_nxt;
  logic [FIDX_W-1:0]    hand_r;
  logic [FAULT_W-1:0]   faults_r;

  // Search results
  logic                  hit_r;
  logic [FIDX_W-1:0]     sel_r;
  logic [MAX_FRAMES-1:0] vis_r;

  // Result registers
  logic                 out_valid_r;
  logic                 out_was_hit_r;
  logic [FIDX_W-1:0]    out_frame_index_r;
  logic                 out_evicted_valid_r;
  logic [PAGE_BITS-1:0] out_evicted_page_r;

  // Combinational search
  logic [CNT_W-1:0]      nf;
  logic [MAX_FRAMES-1:0] act;
  logic [FIDX_W-1:0]     h_eff;
  logic                  hit;
  logic [FIDX_W-1:0]     hit_idx;
  logic                  hi_found;
  logic [FIDX_W-1:0]     hi_idx;
  logic                  lo_found;
  logic [FIDX_W-1:0]     lo_idx;
  logic [FIDX_W-1:0]     victim;
  logic [MAX_FRAMES-1:0] vis;
  logic [CNT_W-1:0]      hand_inc;

  // Clamp the frame count to 1..MAX_FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      nf = CNT_W'(1);
    end else if (32'(cfg_r) > 32'(MAX_FRAMES)) begin
      nf = CNT_W'(MAX_FRAMES);
    end else begin
      nf = CNT_W'(cfg_r);
    end
  end

  // Wrap a hand that lies beyond the active frames
  assign h_eff = (32'(hand_r) >= 32'(nf)) ? '0 : hand_r;

  // Compare tags and find the first clear use bit from the hand
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    hi_found = 1'b0;
    hi_idx   = '0;
    lo_found = 1'b0;
    lo_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      act[i] = 32'(i) < 32'(nf);
      if (act[i] && valid_r[i] && (frame_page_r[i] == page_r)) begin
        hit     = 1'b1;
        hit_idx = FIDX_W'(i);
      end
      if (act[i] && !use_r[i] && (32'(i) >= 32'(h_eff))) begin
        hi_found = 1'b1;
        hi_idx   = FIDX_W'(i);
      end
      if (act[i] && !use_r[i] && (32'(i) < 32'(h_eff))) begin
        lo_found = 1'b1;
        lo_idx   = FIDX_W'(i);
      end
    end
  end

  assign victim = hi_found ? hi_idx : (lo_found ? lo_idx : h_eff);

  // Mark the frames the hand sweeps past
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (hi_found) begin
        vis[i] = (32'(i) >= 32'(h_eff)) && (32'(i) < 32'(victim));
      end else if (lo_found) begin
        vis[i] = act[i] && ((32'(i) >= 32'(h_eff)) || (32'(i) < 32'(victim)));
      end else begin
        vis[i] = act[i];
      end
    end
  end

  // Clear swept use bits on a miss and set the chosen one
  always_comb begin
    use_nxt = use_r & ~vis_r;
    if (hit_r) use_nxt = use_r;
    use_nxt[sel_r] = 1'b1;
  end

  assign hand_inc = CNT_W'(sel_r) + CNT_W'(1);

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      valid_r     <= '0;
      use_r       <= '0;
      hand_r      <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        use_r <= use_nxt;
        if (!hit_r) begin
          valid_r[sel_r] <= 1'b1;
          hand_r         <= (hand_inc >= nf) ? '0 : FIDX_W'(hand_inc);
          if (faults_r != '1) faults_r <= faults_r + FAULT_W'(1);
        end
      end
    end
  end

  // Capture request, search results and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) page_r <= in_page_number;
    if (cmd.search) begin
      hit_r <= hit;
      sel_r <= hit ? hit_idx : victim;
      vis_r <= vis;
    end
    if (cmd.commit) begin
      if (!hit_r) frame_page_r[sel_r] <= page_r;
      out_was_hit_r       <= hit_r;
      out_frame_index_r   <= sel_r;
      out_evicted_valid_r <= !hit_r && valid_r[sel_r];
      out_evicted_page_r  <= (!hit_r && valid_r[sel_r]) ? frame_page_r[sel_r] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_was_hit       = out_was_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_faults_so_far = faults_r;

  // Checks
  `SCPR_ASSERT(a_strobe_after_commit, clk, rst_n,
               out_valid_r |-> $past(cmd.commit),
               "result strobe without commit")
  `SCPR_ASSERT(a_sel_frame_valid, clk, rst_n,
               cmd.commit |=> valid_r[$past(sel_r)],
               "chosen frame not valid after commit")
  `SCPR_ASSERT(a_fault_step, clk, rst_n,
               $past(rst_n) |-> (faults_r == $past(faults_r) ||
                                 faults_r == $past(faults_r) + FAULT_W'(1)),
               "fault count jumped")
  `SCPR_ASSERT_NEVER(a_hit_no_evict, clk, rst_n,
                     out_valid_r && out_was_hit_r && out_evicted_valid_r,
                     "eviction reported on a hit")

endmodule

`default_nettype wire

/* design/second_chance_page_replacement.sv */
// ----------------------------------------------------------------------------
// second_chance_page_replacement
// Clock (second chance) page replacement over up to MAX_FRAMES frames.
// ----------------------------------------------------------------------------
// out_valid pulses for one cycle, after the search and commit states.
// A new request is taken while the previous one commits; busy is high in the
//   search state, where the tag compare and use-bit search are registered.
// The receiver cannot stall; each result is marked by out_valid for one cycle.
// Reset (rst_n low, synchronous) clears valid and use bits, the hand, the
//   fault count, and sets the frame count to 16; frame tags are not cleared.
`default_nettype none

module second_chance_page_replacement
  import scpr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PAGE_BITS-1:0] in_page_number,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output logic                      out_valid,
  output logic                      out_was_hit,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] out_frame_index,
  output logic                      out_evicted_valid,
  output logic [PAGE_BITS-1:0]      out_evicted_page,
  output logic [FAULT_W-1:0]        out_faults_so_far
);

  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  scpr_cmd_t cmd;

  // Sequence requests
  scpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Frame state and search
  scpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .FIDX_W     (FIDX_W)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page_number    (in_page_number),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_was_hit       (out_was_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_faults_so_far (out_faults_so_far)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench: second chance page replacement
// Drives page references and frame count writes into the block, tracks the
// clock policy in a local tracker and compares every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import scpr_pkg::*;

  localparam int  NUM_FRAMES  = 16;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  IDLE_PCT    = 23;

  typedef struct packed {
    logic        was_hit;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [15:0] faults_so_far;
  } outcome_t;

  // Tracks frame contents, use bits, hand and fault total of the clock policy
  class clock_ledger;
    logic [15:0] frame_tag[NUM_FRAMES];
    logic        resident[NUM_FRAMES];
    logic        referenced[NUM_FRAMES];
    int          hand;
    logic [15:0] fault_total;
    logic [4:0]  frame_limit;
    outcome_t    outcomes[$];
    int          mismatches;

    function new();
      for (int f = 0; f < NUM_FRAMES; f++) begin
        frame_tag[f]  = '0;
        resident[f]   = 1'b0;
        referenced[f] = 1'b0;
      end
      hand        = 0;
      fault_total = '0;
      frame_limit = CFG_RESET;
      mismatches  = 0;
    endfunction

    function void set_frames(logic [4:0] value);
      frame_limit = value;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Work out the outcome of one accepted request and queue it
    function void note_reference(logic [15:0] page);
      outcome_t o;
      int       lim;
      lim = int'(frame_limit);
      if (lim < 1) lim = 1;
      if (lim > NUM_FRAMES) lim = NUM_FRAMES;
      o = '0;
      // lowest matching resident frame wins
      for (int f = 0; f < lim; f++) begin
        if (!o.was_hit && resident[f] && frame_tag[f] == page) begin
          o.was_hit     = 1'b1;
          o.frame_index = 4'(f);
        end
      end
      if (o.was_hit) begin
        referenced[o.frame_index] = 1'b1;
      end else begin
        if (fault_total != 16'hFFFF) fault_total++;
        if (hand >= lim) hand = 0;
        // sweep: clear use bits until a clear one is found
        while (referenced[hand]) begin
          referenced[hand] = 1'b0;
          hand++;
          if (hand >= lim) hand = 0;
        end
        o.frame_index = 4'(hand);
        if (resident[hand]) begin
          o.evicted_valid = 1'b1;
          o.evicted_page  = frame_tag[hand];
        end
        frame_tag[hand]  = page;
        resident[hand]   = 1'b1;
        referenced[hand] = 1'b1;
        hand++;
        if (hand >= lim) hand = 0;
      end
      o.faults_so_far = fault_total;
      outcomes.push_back(o);
    endfunction

    // Compare one result with the oldest pending outcome
    task check_outcome(outcome_t got);
      outcome_t want;
      if (outcomes.size() == 0) begin
        report("result with no pending request");
        return;
      end
      want = outcomes.pop_front();
      if (got.was_hit !== want.was_hit)
        report($sformatf("was_hit got %b want %b", got.was_hit, want.was_hit));
      if (got.frame_index !== want.frame_index)
        report($sformatf("frame_index got %0d want %0d",
                         got.frame_index, want.frame_index));
      if (got.evicted_valid !== want.evicted_valid)
        report($sformatf("evicted_valid got %b want %b",
                         got.evicted_valid, want.evicted_valid));
      if (got.evicted_page !== want.evicted_page)
        report($sformatf("evicted_page got %h want %h",
                         got.evicted_page, want.evicted_page));
      if (got.faults_so_far !== want.faults_so_far)
        report($sformatf("faults_so_far got %0d want %0d",
                         got.faults_so_far, want.faults_so_far));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [15:0]       in_page_number;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              out_valid;
  logic              out_was_hit;
  logic [3:0]        out_frame_index;
  logic              out_evicted_valid;
  logic [15:0]       out_evicted_page;
  logic [FAULT_W-1:0] out_faults_so_far;

  clock_ledger ledger;
  bit          idle_on;
  int          cycles;

  second_chance_page_replacement i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_was_hit       (out_was_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_faults_so_far (out_faults_so_far)
  );

  // Generate clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("second_chance_page_replacement test failed");
      $finish;
    end
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ledger.check_outcome('{out_was_hit, out_frame_index, out_evicted_valid,
                             out_evicted_page, out_faults_so_far});
    end
  end

  // Issue one request; hold it until the block takes it
  task automatic send_reference(input logic [15:0] page);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) @(negedge clk);
    end
    start          = 1'b1;
    in_page_number = page;
    do @(posedge clk); while (busy);
    ledger.note_reference(page);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Hold off until every pending outcome has arrived
  task automatic drain();
    while (ledger.outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the frame count while the block is idle
  task automatic write_frames(input logic [4:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.set_frames(value);
  endtask

  initial begin
    logic [4:0]  phase_cfg;
    logic [15:0] pool_base;
    int          pool_span;
    int          lim;
    logic [4:0]  extremes[5];

    ledger         = new();
    cycles         = 0;
    idle_on        = 1'b1;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_page_number = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    extremes       = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty frames, extreme pages, hits after fill
    send_reference(16'h0000);
    send_reference(16'hFFFF);
    send_reference(16'h0000);
    send_reference(16'hFFFF);
    send_reference(16'h5555);
    send_reference(16'hAAAA);
    // Shrink to one frame: hand wraps, page 5555 gets a second copy in frame 0
    write_frames(5'd1);
    send_reference(16'h5555);
    send_reference(16'h5555);
    // Grow back: duplicate copies, lowest frame wins
    write_frames(5'd16);
    send_reference(16'h5555);
    send_reference(16'hFFFF);
    send_reference(16'hAAAA);
    // Zero frame count acts as one frame
    write_frames(5'd0);
    send_reference(16'h0001);
    send_reference(16'h0002);
    send_reference(16'h0002);
    // Count above maximum acts as the maximum
    write_frames(5'd31);
    send_reference(16'h0003);
    send_reference(16'hAAAA);
    send_reference(16'h8000);
    write_frames(5'd17);
    send_reference(16'h0001);
    send_reference(16'h7FFF);
    send_reference(16'h0003);

    // Random phases: each with its own frame count and page pool
    for (int ph = 0; ph < 12; ph++) begin
      phase_cfg = (ph < 5) ? extremes[ph] : 5'($urandom_range(31));
      write_frames(phase_cfg);
      lim = (phase_cfg == 0) ? 1 : (phase_cfg > 16) ? 16 : int'(phase_cfg);
      pool_base = 16'($urandom);
      pool_span = lim + $urandom_range(lim + 2);
      idle_on   = (ph != 6);
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(99) < 70)
          send_reference(pool_base ^ 16'($urandom_range(pool_span - 1)));
        else
          send_reference(16'($urandom));
      end
    end

    // Run back-to-back misses on a single frame
    write_frames(5'd1);
    idle_on = 1'b0;
    for (int n = 0; n < 20; n++) begin
      send_reference(n[0] ? 16'h0F0F : 16'hF0F0);
    end
    idle_on = 1'b1;
    send_reference(16'hF0F0);
    send_reference(16'h1234);

    // Wait out the last results
    while (ledger.outcomes.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (ledger.outcomes.size() != 0)
      ledger.report("outcomes left over at end of run");
    if (ledger.mismatches == 0) begin
      $display("second_chance_page_replacement test passed");
    end else begin
      $display("second_chance_page_replacement test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* second_chance_page_replacement.f */
+incdir+design
design/scpr_pkg.sv
design/scpr_ctrl.sv
design/scpr_datapath.sv
design/second_chance_page_replacement.sv
bench/testbench.sv
